// ===== src/upq_pkg.sv =====
// shared types, constants and the entry ordering for the unsorted array priority queue
// no dependencies

package upq_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int PRIO_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 3;
   localparam int OUT_CNT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 3'd0,
      CMD_DEQUEUE = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_CHANGE  = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_NOT_LOWER = 3'd3,
      STS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // smaller signed priority first, ties go to the smaller key
   function automatic logic entry_less(entry_type a, entry_type b);
      logic prio_lt;
      logic prio_eq;
      prio_lt = $signed(a.prio) < $signed(b.prio);
      prio_eq = a.prio == b.prio;
      return prio_lt || (prio_eq && (a.key < b.key));
   endfunction

endpackage

// ===== src/unsorted_array_priority_queue.sv =====
// top level of the unsorted array priority queue: command sequencer and entry memory
// depends on upq_pkg

// Min-priority queue of up to upq_pkg::CAPACITY (key, priority) entries kept unsorted in one
// synchronous memory with a single read and a single write port. A command is taken when start
// is high and busy is low; exactly one result follows, shown for one cycle with rsp_valid high,
// and it cannot be held off. Enqueue, clear and unused codes give their result straight from the
// dispatch state, with no scan. Dequeue, peek and change priority walk the held entries through
// the one read port, one entry per cycle, so with n entries held they read up to n entries (change
// priority stops at the first matching key). busy drops in the cycle the result is shown, so the
// next command can be taken in that cycle. There is no clearing pass: after reset the count is
// zero and the memory contents are never read before being written.

module unsorted_array_priority_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [upq_pkg::CMD_W-1:0]       req_command,
   input  logic [upq_pkg::KEY_W-1:0]       req_entry_key,
   input  logic signed [upq_pkg::PRIO_W-1:0] req_entry_priority,
   output logic                            rsp_valid,
   output logic [upq_pkg::KEY_W-1:0]       rsp_result_key,
   output logic signed [upq_pkg::PRIO_W-1:0] rsp_result_priority,
   output logic [upq_pkg::STATUS_W-1:0]    rsp_status,
   output logic [upq_pkg::OUT_CNT_W-1:0]   rsp_entry_count
);

   upq_pkg::state_type state_ff, state_in;

   logic [upq_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [upq_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [upq_pkg::PRIO_W-1:0]    prio_ff, prio_in;
   logic [upq_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [upq_pkg::IDX_W-1:0]     data_idx_ff, data_idx_in;
   upq_pkg::entry_type            best_ff, best_in;
   logic [upq_pkg::IDX_W-1:0]     best_idx_ff, best_idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [upq_pkg::KEY_W-1:0]     rsp_key_ff, rsp_key_in;
   logic [upq_pkg::PRIO_W-1:0]    rsp_prio_ff, rsp_prio_in;
   logic [upq_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [upq_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // entry memory
   upq_pkg::entry_type            entry_mem [upq_pkg::CAPACITY];
   upq_pkg::entry_type            rd_data_ff;
   logic                          rd_en;
   logic [upq_pkg::IDX_W-1:0]     rd_addr;
   logic                          wr_en;
   logic [upq_pkg::IDX_W-1:0]     wr_addr;
   upq_pkg::entry_type            wr_data;

   logic                          accept;
   logic                          is_scan_cmd;
   logic                          is_change;
   logic                          scan_last;
   logic                          scan_hit;
   logic                          take_new;
   upq_pkg::entry_type            best_sel;
   logic [upq_pkg::IDX_W-1:0]     best_sel_idx;

   assign busy   = state_ff != upq_pkg::S_IDLE;
   assign accept = start && !busy;

   assign is_change   = cmd_ff == upq_pkg::CMD_CHANGE;
   assign is_scan_cmd = cmd_ff inside {upq_pkg::CMD_DEQUEUE, upq_pkg::CMD_PEEK,
                                       upq_pkg::CMD_CHANGE};

   // rd_data_ff holds the entry at data_idx_ff while scanning
   assign scan_last = (upq_pkg::COUNT_W'(data_idx_ff) + upq_pkg::COUNT_W'(1)) == count_ff;
   assign scan_hit  = is_change && (rd_data_ff.key == key_ff);

   assign take_new     = (data_idx_ff == '0) || upq_pkg::entry_less(rd_data_ff, best_ff);
   assign best_sel     = take_new ? rd_data_ff : best_ff;
   assign best_sel_idx = take_new ? data_idx_ff : best_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         upq_pkg::S_IDLE: begin
            if (accept) begin
               state_in = upq_pkg::S_DISPATCH;
            end
         end
         upq_pkg::S_DISPATCH: begin
            if (is_scan_cmd && (count_ff != '0)) begin
               state_in = upq_pkg::S_SCAN;
            end else begin
               state_in = upq_pkg::S_IDLE;
            end
         end
         upq_pkg::S_SCAN: begin
            if (scan_last || scan_hit) begin
               state_in = upq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = upq_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      prio_in       = prio_ff;
      count_in      = count_ff;
      data_idx_in   = data_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_key_in    = '0;
      rsp_prio_in   = '0;
      rsp_status_in = upq_pkg::STS_OK;
      rsp_count_in  = count_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      case (state_ff)
         upq_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in  = req_command;
               key_in  = req_entry_key;
               prio_in = req_entry_priority;
            end
         end
         upq_pkg::S_DISPATCH: begin
            case (upq_pkg::cmd_type'(cmd_ff))
               upq_pkg::CMD_ENQUEUE: begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == upq_pkg::COUNT_W'(upq_pkg::CAPACITY)) begin
                     rsp_status_in = upq_pkg::STS_FULL;
                  end else begin
                     wr_en        = 1'b1;
                     wr_addr      = upq_pkg::IDX_W'(count_ff);
                     wr_data.key  = key_ff;
                     wr_data.prio = prio_ff;
                     count_in     = count_ff + upq_pkg::COUNT_W'(1);
                     rsp_count_in = count_ff + upq_pkg::COUNT_W'(1);
                  end
               end
               upq_pkg::CMD_DEQUEUE, upq_pkg::CMD_PEEK, upq_pkg::CMD_CHANGE: begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = is_change ? upq_pkg::STS_NOT_FOUND : upq_pkg::STS_EMPTY;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = '0;
                     data_idx_in = '0;
                  end
               end
               upq_pkg::CMD_CLEAR: begin
                  rsp_valid_in = 1'b1;
                  count_in     = '0;
                  rsp_count_in = '0;
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         upq_pkg::S_SCAN: begin
            best_in     = best_sel;
            best_idx_in = best_sel_idx;
            if (is_change) begin
               if (scan_hit) begin
                  rsp_valid_in = 1'b1;
                  if ($signed(prio_ff) < $signed(rd_data_ff.prio)) begin
                     wr_en         = 1'b1;
                     wr_addr       = data_idx_ff;
                     wr_data.key   = rd_data_ff.key;
                     wr_data.prio  = prio_ff;
                     rsp_status_in = upq_pkg::STS_OK;
                  end else begin
                     rsp_status_in = upq_pkg::STS_NOT_LOWER;
                  end
               end else if (scan_last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = upq_pkg::STS_NOT_FOUND;
               end
            end else if (scan_last) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = best_sel.key;
               rsp_prio_in  = best_sel.prio;
               if (cmd_ff == upq_pkg::CMD_DEQUEUE) begin
                  // the last entry is the one just read: move it into the freed slot
                  wr_en        = 1'b1;
                  wr_addr      = best_sel_idx;
                  wr_data      = rd_data_ff;
                  count_in     = count_ff - upq_pkg::COUNT_W'(1);
                  rsp_count_in = count_ff - upq_pkg::COUNT_W'(1);
               end
            end
            if (!scan_last && !scan_hit) begin
               rd_en       = 1'b1;
               rd_addr     = data_idx_ff + upq_pkg::IDX_W'(1);
               data_idx_in = data_idx_ff + upq_pkg::IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= upq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      prio_ff       <= prio_in;
      data_idx_ff   <= data_idx_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_key      = rsp_key_ff;
   assign rsp_result_priority = rsp_prio_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_count     = upq_pkg::OUT_CNT_W'(rsp_count_ff);

endmodule

// ===== src/upq_checker.sv =====
// port-level checks for the unsorted array priority queue, bound to the top level
// depends on upq_pkg and unsorted_array_priority_queue

module upq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [upq_pkg::CMD_W-1:0]         req_command,
   input logic [upq_pkg::KEY_W-1:0]         req_entry_key,
   input logic signed [upq_pkg::PRIO_W-1:0] req_entry_priority,
   input logic                              rsp_valid,
   input logic [upq_pkg::KEY_W-1:0]         rsp_result_key,
   input logic signed [upq_pkg::PRIO_W-1:0] rsp_result_priority,
   input logic [upq_pkg::STATUS_W-1:0]      rsp_status,
   input logic [upq_pkg::OUT_CNT_W-1:0]     rsp_entry_count
);

   // a taken item keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an item was taken");

   // no result in the cycle right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid)
      else $error("result shown too early");

   // the block is ready again when a result is shown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy while a result is shown");

   // an empty queue returns no entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == upq_pkg::STS_EMPTY)) |->
         ((rsp_result_key == '0) && (rsp_result_priority == '0) && (rsp_entry_count == '0)))
      else $error("empty result carries data");

   // count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= upq_pkg::OUT_CNT_W'(upq_pkg::CAPACITY)))
      else $error("entry count above capacity");

endmodule

bind unsorted_array_priority_queue upq_checker u_upq_checker (.*);
